/* rtl/acdm_pkg.sv */
// Shared types, constants and coefficient tables of the downmix matrix.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package acdm_pkg;

	localparam int SAMPLE_BITS          = 24;
	localparam int ACDM_MAX_IN_CHANNELS = 8;
	localparam int ACDM_COEF_FRAC_BITS  = 14;
	localparam int FRAME_CHANNELS       = 8;
	localparam int MIX_OUTS             = 6;
	localparam int CFG_BITS             = 4;
	localparam int CFG_IDX_BITS         = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IN_CHANNELS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_LAYOUT  = 2'd1;

	localparam logic LAYOUT_STEREO = 1'b0;
	localparam logic LAYOUT_5_1    = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_0;
		logic signed [SAMPLE_BITS-1:0] sample_1;
		logic signed [SAMPLE_BITS-1:0] sample_2;
		logic signed [SAMPLE_BITS-1:0] sample_3;
		logic signed [SAMPLE_BITS-1:0] sample_4;
		logic signed [SAMPLE_BITS-1:0] sample_5;
		logic signed [SAMPLE_BITS-1:0] sample_6;
		logic signed [SAMPLE_BITS-1:0] sample_7;
		logic                          frame_last;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] mix_0;
		logic signed [SAMPLE_BITS-1:0] mix_1;
		logic signed [SAMPLE_BITS-1:0] mix_2;
		logic signed [SAMPLE_BITS-1:0] mix_3;
		logic signed [SAMPLE_BITS-1:0] mix_4;
		logic signed [SAMPLE_BITS-1:0] mix_5;
		logic                          layout_error;
		logic                          mix_last;
	} mix_t;

	// Matrix selection handed to every lane.
	typedef struct packed {
		logic       ok;
		logic       layout;
		logic [3:0] chans;
	} mtx_sel_t;

	// Per-request flags that travel alongside the data path.
	typedef struct packed {
		logic vld;
		logic err;
		logic last;
	} tag_t;

	// Gain magnitudes in Q30: 0, 1, 1/2, sqrt(1/2), sqrt(2/3), sqrt(1/3), sqrt(1/6).
	localparam logic [31:0] Q30_MAG [8] = '{
		32'd0, 32'd1073741824, 32'd536870912, 32'd759250125,
		32'd876706528, 32'd619925131, 32'd438353264, 32'd0
	};

	// Gain codes per (channel count - 1, input channel, output L/R); negative negates.
	localparam int ST_TAB [8][8][2] = '{
		'{'{1,1},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{1,1},  '{0,0},  '{0,0},  '{0,0},  '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{3,3},  '{-3,3}, '{0,0},  '{0,0},  '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{3,3},  '{4,-5}, '{-5,4}, '{0,0},  '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{3,3},  '{0,0},  '{4,-5}, '{-5,4}, '{0,0},  '{0,0}},
		'{'{1,0},  '{0,1},  '{3,3},  '{0,0},  '{2,2},  '{4,-5}, '{-5,4}, '{0,0}},
		'{'{1,0},  '{0,1},  '{3,3},  '{0,0},  '{5,-6}, '{-6,5}, '{5,-6}, '{-6,5}}
	};

	// Gain codes per (channel count - 6, input channel, output) for 5.1.
	localparam int S51_TAB [3][8][6] = '{
		'{'{1,0,0,0,0,0}, '{0,1,0,0,0,0}, '{0,0,1,0,0,0}, '{0,0,0,1,0,0},
		  '{0,0,0,0,1,0}, '{0,0,0,0,0,1}, '{0,0,0,0,0,0}, '{0,0,0,0,0,0}},
		'{'{1,0,0,0,0,0}, '{0,1,0,0,0,0}, '{0,0,1,0,0,0}, '{0,0,0,1,0,0},
		  '{0,0,0,0,3,3}, '{0,0,0,0,1,0}, '{0,0,0,0,0,1}, '{0,0,0,0,0,0}},
		'{'{1,0,0,0,0,0}, '{0,1,0,0,0,0}, '{0,0,1,0,0,0}, '{0,0,0,1,0,0},
		  '{0,0,0,0,3,0}, '{0,0,0,0,0,3}, '{0,0,0,0,3,0}, '{0,0,0,0,0,3}}
	};

	function automatic logic signed [3:0] coef_code(
		input logic       layout,
		input logic [3:0] chans,
		input int         lane,
		input int         outp
	);
		logic [2:0]        ni;
		logic [1:0]        si;
		logic signed [3:0] code;
		ni   = 3'(chans - 4'd1);
		si   = 2'(chans - 4'd6);
		code = '0;
		if (layout == LAYOUT_5_1) begin
			if (chans >= 4'd6 && chans <= 4'd8)
				code = 4'(S51_TAB[si][lane][outp]);
		end else if (outp < 2 && chans >= 4'd1 && chans <= 4'd8) begin
			code = 4'(ST_TAB[ni][lane][outp]);
		end
		return code;
	endfunction

	// Round the Q30 magnitude to frac fractional bits, half away from zero.
	function automatic logic signed [31:0] coef_value(
		input logic signed [3:0] code,
		input int                frac
	);
		logic        neg;
		logic [3:0]  idx;
		logic [31:0] q;
		neg = code[3];
		idx = neg ? 4'(-code) : 4'(code);
		q   = (Q30_MAG[idx[2:0]] + (32'd1 << (29 - frac))) >> (30 - frac);
		return neg ? -$signed(q) : $signed(q);
	endfunction

endpackage

`default_nettype wire

/* rtl/acdm_lane.sv */
// One input-channel lane: looks up its six gains and multiplies its sample.
// Depends on acdm_pkg.
`default_nettype none

module acdm_lane
	import acdm_pkg::*;
#(
	parameter int LANE           = 0,
	parameter int COEF_FRAC_BITS = ACDM_COEF_FRAC_BITS,
	localparam int CW            = COEF_FRAC_BITS + 2,
	localparam int PW            = SAMPLE_BITS + CW
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  mtx_sel_t                      sel,
	output logic signed [PW-1:0]          prod_s1 [MIX_OUTS]
);

	logic signed [3:0]    code   [MIX_OUTS];
	logic signed [CW-1:0] coef   [MIX_OUTS];
	logic signed [PW-1:0] prod_d [MIX_OUTS];

	always_comb begin
		for (int i = 0; i < MIX_OUTS; i++) begin
			code[i]   = sel.ok ? coef_code(sel.layout, sel.chans, LANE, i) : 4'sd0;
			coef[i]   = CW'(coef_value(code[i], COEF_FRAC_BITS));
			prod_d[i] = sample * coef[i];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
	end

endmodule

`default_nettype wire

/* rtl/acdm_merge.sv */
// Merging stage: sums lane products per output, then rounds and saturates.
// Depends on acdm_pkg.
`default_nettype none

module acdm_merge
	import acdm_pkg::*;
#(
	parameter int MAX_IN_CHANNELS = ACDM_MAX_IN_CHANNELS,
	parameter int COEF_FRAC_BITS  = ACDM_COEF_FRAC_BITS,
	localparam int PW             = SAMPLE_BITS + COEF_FRAC_BITS + 2,
	localparam int SW             = PW + $clog2(MAX_IN_CHANNELS),
	localparam int RW             = SW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tag_t                 tag_s1,
	input  logic signed [PW-1:0] prod_s1 [MAX_IN_CHANNELS][MIX_OUTS],
	output logic                 done,
	output mix_t                 mix
);

	localparam logic signed [RW-1:0] SAT_HI =
		{{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] SAT_LO =
		{{(RW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [RW-1:0] HALF = RW'(1) << (COEF_FRAC_BITS - 1);

	logic signed [SW-1:0]          sum_d  [MIX_OUTS];
	logic signed [SW-1:0]          sum_s2 [MIX_OUTS];
	tag_t                          tag_s2;
	logic signed [RW-1:0]          rnd    [MIX_OUTS];
	logic signed [RW-1:0]          shr    [MIX_OUTS];
	logic signed [SAMPLE_BITS-1:0] sat    [MIX_OUTS];
	mix_t                          mix_s3;
	logic                          done_s3;

	always_comb begin
		for (int i = 0; i < MIX_OUTS; i++) begin
			sum_d[i] = '0;
			for (int j = 0; j < MAX_IN_CHANNELS; j++)
				sum_d[i] = sum_d[i] + SW'(prod_s1[j][i]);
		end
	end

	// Round half toward +inf, then clamp to the sample range.
	always_comb begin
		for (int i = 0; i < MIX_OUTS; i++) begin
			rnd[i] = RW'(sum_s2[i]) + HALF;
			shr[i] = rnd[i] >>> COEF_FRAC_BITS;
			if (shr[i] > SAT_HI)
				sat[i] = SAT_HI[SAMPLE_BITS-1:0];
			else if (shr[i] < SAT_LO)
				sat[i] = SAT_LO[SAMPLE_BITS-1:0];
			else
				sat[i] = shr[i][SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_d;
		mix_s3.mix_0        <= sat[0];
		mix_s3.mix_1        <= sat[1];
		mix_s3.mix_2        <= sat[2];
		mix_s3.mix_3        <= sat[3];
		mix_s3.mix_4        <= sat[4];
		mix_s3.mix_5        <= sat[5];
		mix_s3.layout_error <= tag_s2.err;
		mix_s3.mix_last     <= tag_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2  <= '0;
			done_s3 <= 1'b0;
		end else begin
			tag_s2  <= tag_s1;
			done_s3 <= tag_s2.vld;
		end
	end

	assign done = done_s3;
	assign mix  = mix_s3;

endmodule

`default_nettype wire

/* rtl/audio_channel_downmix_matrix_top.sv */
// Top level of the surround downmix matrix: config registers, lanes, merge.
// Depends on acdm_pkg, acdm_lane and acdm_merge.
//
//   channel   direction  handshake            payload
//   request   in         start, busy          frame (frame_t)
//   result    out        done (1-cycle pulse) mix (mix_t)
//   config    in         cfg_we               cfg_idx, cfg_data
//
// One request per cycle is taken; busy is held low since the pipeline never
// backs up. Each result passes through stage 1, the per-lane multipliers,
// stage 2, the lane-sum tree, and stage 3, round and clamp.
// Reset clears the valid pipeline and sets 2 channels, stereo layout.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module audio_channel_downmix_matrix_top
	import acdm_pkg::*;
#(
	parameter int MAX_IN_CHANNELS = ACDM_MAX_IN_CHANNELS,
	parameter int COEF_FRAC_BITS  = ACDM_COEF_FRAC_BITS,
	localparam int PW             = SAMPLE_BITS + COEF_FRAC_BITS + 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  frame_t                  frame,
	output logic                    done,
	output mix_t                    mix,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [3:0]                    in_channels_q;
	logic                          out_layout_q;
	logic                          accept;
	mtx_sel_t                      sel;
	tag_t                          tag_s1;
	logic signed [SAMPLE_BITS-1:0] samp    [FRAME_CHANNELS];
	logic signed [PW-1:0]          prod_s1 [MAX_IN_CHANNELS][MIX_OUTS];

	// Never back-pressure: every stage advances each cycle.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q <= 4'd2;
			out_layout_q  <= LAYOUT_STEREO;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IN_CHANNELS: in_channels_q <= cfg_data;
				CFG_OUT_LAYOUT:  out_layout_q  <= cfg_data[0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Pick the matrix; an unsupported pairing zeroes every gain.
	always_comb begin
		sel.layout = out_layout_q;
		sel.chans  = in_channels_q;
		if (out_layout_q == LAYOUT_5_1)
			sel.ok = in_channels_q >= 4'd6 && in_channels_q <= 4'd8
			         && in_channels_q <= 4'(MAX_IN_CHANNELS);
		else
			sel.ok = in_channels_q >= 4'd2 && in_channels_q <= 4'd8
			         && in_channels_q <= 4'(MAX_IN_CHANNELS);
	end

	assign samp[0] = frame.sample_0;
	assign samp[1] = frame.sample_1;
	assign samp[2] = frame.sample_2;
	assign samp[3] = frame.sample_3;
	assign samp[4] = frame.sample_4;
	assign samp[5] = frame.sample_5;
	assign samp[6] = frame.sample_6;
	assign samp[7] = frame.sample_7;

	// Hold the request flags beside the stage-1 products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld  <= accept;
			tag_s1.err  <= !sel.ok;
			tag_s1.last <= frame.frame_last;
		end
	end

	// One lane per supported input channel; higher counts are rejected.
	for (genvar g = 0; g < MAX_IN_CHANNELS; g++) begin : g_lane
		acdm_lane #(
			.LANE           (g),
			.COEF_FRAC_BITS (COEF_FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.sample  (samp[g]),
			.sel     (sel),
			.prod_s1 (prod_s1[g])
		);
	end

	acdm_merge #(
		.MAX_IN_CHANNELS (MAX_IN_CHANNELS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.prod_s1 (prod_s1),
		.done    (done),
		.mix     (mix)
	);

endmodule

`default_nettype wire

/* rtl/acdm_checker.sv */
// Port-level checks of the downmix matrix, bound to the top level.
// Depends on acdm_pkg and audio_channel_downmix_matrix_top.
`default_nettype none

module acdm_checker
	import acdm_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input frame_t frame,
	input logic   done,
	input mix_t   mix
);

	logic accept;
	assign accept = start && !busy;

	// Every request yields a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("request did not produce a result after three cycles");

	// No result without a matching earlier request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without a matching request");

	// The last-frame mark follows its own frame.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> mix.mix_last == $past(frame.frame_last, 3))
		else $error("mix_last does not match frame_last of its request");

	// An unsupported pairing returns silence.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mix.layout_error) |->
			(mix.mix_0 == 0 && mix.mix_1 == 0 && mix.mix_2 == 0 &&
			 mix.mix_3 == 0 && mix.mix_4 == 0 && mix.mix_5 == 0))
		else $error("layout error with nonzero outputs");

endmodule

bind audio_channel_downmix_matrix_top acdm_checker u_acdm_checker (.*);

`default_nettype wire

/* tb/sv/acdm_mix_checker.sv */
// Downmix result checker: predicts each mix from the accepted frame and the
// register copy it keeps, then compares results in order. Depends on acdm_pkg.
`timescale 1ns / 100ps

module acdm_mix_checker
	import acdm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  frame_t                  frame,
	input  logic                    done,
	input  mix_t                    mix,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output int                      pending_mixes,
	output int                      mismatch_count
);

	// Gains in Q2.14, each the real value rounded to nearest.
	localparam int     FRAC        = 14;
	localparam longint GAIN_ONE    = 16384;
	localparam longint GAIN_HALF   = 8192;
	localparam longint GAIN_RT_1_2 = 11585;
	localparam longint GAIN_RT_2_3 = 13377;
	localparam longint GAIN_RT_1_3 = 9459;
	localparam longint GAIN_RT_1_6 = 6689;
	localparam longint MIX_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint MIX_MIN     = -MIX_MAX - 1;
	localparam int     PRINT_CAP   = 200;

	logic [CFG_BITS-1:0] chans_q;
	logic                layout_q;
	mix_t                expected_mix [$];
	mix_t                want;

	function automatic logic signed [SAMPLE_BITS-1:0] round_clamp(input longint acc);
		longint r;
		r = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
		if (r > MIX_MAX)
			r = MIX_MAX;
		if (r < MIX_MIN)
			r = MIX_MIN;
		return SAMPLE_BITS'(r);
	endfunction

	function automatic mix_t downmix_frame(input frame_t f, input logic [CFG_BITS-1:0] chans,
			input logic layout);
		longint                        s [8];
		longint                        g [6][8];
		longint                        acc;
		logic signed [SAMPLE_BITS-1:0] y [6];
		mix_t                          m;
		m = '0;
		m.mix_last = f.frame_last;
		if (layout == LAYOUT_5_1 ? (chans < 4'd6 || chans > 4'd8)
				: (chans < 4'd2 || chans > 4'd8)) begin
			m.layout_error = 1'b1;
			return m;
		end
		s[0] = longint'($signed(f.sample_0));
		s[1] = longint'($signed(f.sample_1));
		s[2] = longint'($signed(f.sample_2));
		s[3] = longint'($signed(f.sample_3));
		s[4] = longint'($signed(f.sample_4));
		s[5] = longint'($signed(f.sample_5));
		s[6] = longint'($signed(f.sample_6));
		s[7] = longint'($signed(f.sample_7));
		for (int o = 0; o < 6; o++)
			for (int j = 0; j < 8; j++)
				g[o][j] = 0;
		if (layout == LAYOUT_5_1) begin
			for (int k = 0; k < 4; k++)
				g[k][k] = GAIN_ONE;
			case (chans)
			4'd6: begin
				g[4][4] = GAIN_ONE;
				g[5][5] = GAIN_ONE;
			end
			4'd7: begin
				// center surround folds into both surrounds
				g[4][4] = GAIN_RT_1_2;
				g[5][4] = GAIN_RT_1_2;
				g[4][5] = GAIN_ONE;
				g[5][6] = GAIN_ONE;
			end
			default: begin
				g[4][4] = GAIN_RT_1_2;
				g[4][6] = GAIN_RT_1_2;
				g[5][5] = GAIN_RT_1_2;
				g[5][7] = GAIN_RT_1_2;
			end
			endcase
		end else begin
			g[0][0] = GAIN_ONE;
			g[1][1] = GAIN_ONE;
			if (chans >= 4'd4) begin
				g[0][2] = GAIN_RT_1_2;
				g[1][2] = GAIN_RT_1_2;
			end
			case (chans)
			4'd3: begin
				g[0][2] = GAIN_ONE;
				g[1][2] = GAIN_ONE;
			end
			4'd4: begin
				g[0][3] = -GAIN_RT_1_2;
				g[1][3] = GAIN_RT_1_2;
			end
			4'd5: begin
				g[0][3] = GAIN_RT_2_3;
				g[1][3] = -GAIN_RT_1_3;
				g[0][4] = -GAIN_RT_1_3;
				g[1][4] = GAIN_RT_2_3;
			end
			4'd6: begin
				g[0][4] = GAIN_RT_2_3;
				g[1][4] = -GAIN_RT_1_3;
				g[0][5] = -GAIN_RT_1_3;
				g[1][5] = GAIN_RT_2_3;
			end
			4'd7: begin
				g[0][4] = GAIN_HALF;
				g[1][4] = GAIN_HALF;
				g[0][5] = GAIN_RT_2_3;
				g[1][5] = -GAIN_RT_1_3;
				g[0][6] = -GAIN_RT_1_3;
				g[1][6] = GAIN_RT_2_3;
			end
			4'd8: begin
				g[0][4] = GAIN_RT_1_3;
				g[1][4] = -GAIN_RT_1_6;
				g[0][5] = -GAIN_RT_1_6;
				g[1][5] = GAIN_RT_1_3;
				g[0][6] = GAIN_RT_1_3;
				g[1][6] = -GAIN_RT_1_6;
				g[0][7] = -GAIN_RT_1_6;
				g[1][7] = GAIN_RT_1_3;
			end
			default: begin
			end
			endcase
		end
		for (int o = 0; o < 6; o++) begin
			acc = 0;
			for (int j = 0; j < 8; j++)
				acc += s[j] * g[o][j];
			y[o] = round_clamp(acc);
		end
		m.mix_0 = y[0];
		m.mix_1 = y[1];
		m.mix_2 = y[2];
		m.mix_3 = y[3];
		m.mix_4 = y[4];
		m.mix_5 = y[5];
		return m;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic signed [SAMPLE_BITS-1:0] got,
			input logic signed [SAMPLE_BITS-1:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q = 4'd2;
			layout_q = LAYOUT_STEREO;
			expected_mix.delete();
			pending_mixes <= 0;
		end else begin
			// retire before predicting: a result never belongs to the request of its own edge
			if (done === 1'b1) begin
				if (expected_mix.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = expected_mix.pop_front();
					check_field("mix_0", mix.mix_0, want.mix_0);
					check_field("mix_1", mix.mix_1, want.mix_1);
					check_field("mix_2", mix.mix_2, want.mix_2);
					check_field("mix_3", mix.mix_3, want.mix_3);
					check_field("mix_4", mix.mix_4, want.mix_4);
					check_field("mix_5", mix.mix_5, want.mix_5);
					check_field("layout_error", SAMPLE_BITS'(mix.layout_error),
						SAMPLE_BITS'(want.layout_error));
					check_field("mix_last", SAMPLE_BITS'(mix.mix_last),
						SAMPLE_BITS'(want.mix_last));
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done is unknown");
			end
			if (start && !busy)
				expected_mix.push_back(downmix_frame(frame, chans_q, layout_q));
			if (cfg_we) begin
				if (cfg_idx == CFG_IN_CHANNELS)
					chans_q = cfg_data;
				else if (cfg_idx == CFG_OUT_LAYOUT)
					layout_q = cfg_data[0];
			end
			pending_mixes <= expected_mix.size();
		end
	end

endmodule

/* tb/sv/audio_channel_downmix_matrix_top_test.sv */
// Stimulus top for the downmix matrix: clock, reset, register setup and frame
// requests. Depends on acdm_pkg, the RTL top and acdm_mix_checker.
`timescale 1ns / 100ps

module audio_channel_downmix_matrix_top_test;
	import acdm_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	// Indexes past the register list; writes there must be ignored.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;
	localparam int RANDOM_FRAMES  = 900;
	localparam int SETTLE_CYCLES  = 4;     // pipeline is three stages deep
	localparam int WATCHDOG_LIMIT = 1000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	frame_t                  frame;
	logic                    done;
	mix_t                    mix;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CFG_BITS-1:0]     cfg_data;
	int                      pending_mixes;
	int                      mismatch_count;
	int                      quiet_cycles;
	bit                      burst_mode;

	audio_channel_downmix_matrix_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.frame    (frame),
		.done     (done),
		.mix      (mix),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	acdm_mix_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.frame          (frame),
		.done           (done),
		.mix            (mix),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.pending_mixes  (pending_mixes),
		.mismatch_count (mismatch_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: any accepted request or result counts as progress. The longest
	// legal quiet stretch is one long idle gap plus a drain, far below the limit.
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("audio_channel_downmix_matrix_top_test: done, errors");
			$finish;
		end
	end

	// Even-numbered channels get one value, odd-numbered the other, so a
	// single call drives both signs into the positive and negative gains.
	function automatic frame_t fill_frame(input logic signed [SAMPLE_BITS-1:0] even_val,
			input logic signed [SAMPLE_BITS-1:0] odd_val, input logic last);
		frame_t f;
		f.sample_0 = even_val;
		f.sample_1 = odd_val;
		f.sample_2 = even_val;
		f.sample_3 = odd_val;
		f.sample_4 = even_val;
		f.sample_5 = odd_val;
		f.sample_6 = even_val;
		f.sample_7 = odd_val;
		f.frame_last = last;
		return f;
	endfunction

	// Mostly full-range noise, with rails and values near zero mixed in so that
	// saturation and rounding near the tie are hit often.
	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		int v;
		v = $urandom_range(0, 32);
		case ($urandom_range(0, 7))
		0: return SAMPLE_MAX;
		1: return SAMPLE_MIN;
		2: return SAMPLE_BITS'(v - 16);
		default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.sample_0 = rand_sample();
		f.sample_1 = rand_sample();
		f.sample_2 = rand_sample();
		f.sample_3 = rand_sample();
		f.sample_4 = rand_sample();
		f.sample_5 = rand_sample();
		f.sample_6 = rand_sample();
		f.sample_7 = rand_sample();
		f.frame_last = 1'($urandom_range(0, 1));
		return f;
	endfunction

	// Idle length before a request: none in a burst phase, otherwise mostly
	// back-to-back or short, now and then a long hole.
	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 19);
		if (burst_mode || pick < 9)
			return 0;
		if (pick < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Issue one request; return right after the edge that takes it. Start stays
	// high so that a back-to-back request needs only one assignment.
	task automatic send_frame(input frame_t f);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		frame <= f;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Hold off requests until every outstanding mix has come back, then let
	// the pipeline settle. The first edge lets the checker count the last request.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_mixes != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back, optionally preceded by a write to a
	// spare index. Upper bits of the layout word are junk the block must drop.
	task automatic set_mode(input logic [CFG_BITS-1:0] chans, input logic layout,
			input logic [CFG_BITS-2:0] pad, input bit spare);
		cfg_we <= 1'b1;
		if (spare) begin
			cfg_idx <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
			cfg_data <= CFG_BITS'($urandom);
			@(posedge clk);
		end
		cfg_idx <= CFG_IN_CHANNELS;
		cfg_data <= chans;
		@(posedge clk);
		cfg_idx <= CFG_OUT_LAYOUT;
		cfg_data <= {pad, layout};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		frame_t               f;
		int                   frames_sent;
		int                   run_len;
		logic [CFG_BITS-1:0]  chans;
		logic                 layout;
		frames_sent = 0;
		burst_mode = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		frame <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_IN_CHANNELS;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset layout is two channels to stereo: run the rails through it
		// before any register is touched.
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		send_frame(fill_frame('0, '0, 1'b0));

		// Three channels: center at unity gain pushes L and R past the rails.
		drain();
		set_mode(4'd3, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1));

		drain();
		set_mode(4'd4, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0));

		drain();
		set_mode(4'd5, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1));

		drain();
		set_mode(4'd6, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0));

		// Seven channels: the half gain on center surround lands exactly on a
		// rounding tie for a sample of one, which must round up on both signs.
		drain();
		set_mode(4'd7, LAYOUT_STEREO, '0, 1'b0);
		f = fill_frame('0, '0, 1'b0);
		f.sample_4 = SAMPLE_BITS'(1);
		send_frame(f);
		f.sample_4 = SAMPLE_BITS'(-1);
		send_frame(f);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1));

		drain();
		set_mode(4'd8, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0));

		drain();
		set_mode(4'd6, LAYOUT_5_1, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0));

		drain();
		set_mode(4'd7, LAYOUT_5_1, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1));

		drain();
		set_mode(4'd8, LAYOUT_5_1, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1));

		// Invalid pairings: too few channels for either layout, counts past the
		// maximum, and a layout word with junk in its upper bits.
		drain();
		set_mode(4'd1, LAYOUT_STEREO, '0, 1'b1);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		drain();
		set_mode(4'd0, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0));
		drain();
		set_mode(4'd9, LAYOUT_STEREO, '0, 1'b0);
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
		drain();
		set_mode(4'd15, LAYOUT_5_1, '1, 1'b1);
		send_frame(fill_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
		drain();
		set_mode(4'd5, LAYOUT_5_1, '1, 1'b0);
		send_frame(fill_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0));

		// Random phases: drain, pick a mode (mostly valid ones), then a run of
		// frames either back to back or with random holes.
		while (frames_sent < RANDOM_FRAMES) begin
			drain();
			layout = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0)
				chans = CFG_BITS'($urandom_range(0, 15));
			else if (layout == LAYOUT_5_1)
				chans = CFG_BITS'($urandom_range(6, 8));
			else
				chans = CFG_BITS'($urandom_range(2, 8));
			set_mode(chans, layout, (CFG_BITS-1)'($urandom), $urandom_range(0, 3) == 0);
			burst_mode = $urandom_range(0, 3) == 0;
			run_len = $urandom_range(8, 60);
			repeat (run_len) begin
				send_frame(rand_frame());
				frames_sent++;
			end
		end

		drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("audio_channel_downmix_matrix_top_test: done, clean");
		else
			$display("audio_channel_downmix_matrix_top_test: done, errors");
		$finish;
	end

endmodule
